>>> hw/rtl/sdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared widths, register indexes and payload types of the spring force block.
// ----------------------------------------------------------------------------
package sdf_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_REST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STIFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] own_pos_x;
		logic signed [DATA_W-1:0] own_pos_y;
		logic signed [DATA_W-1:0] own_pos_z;
		logic signed [DATA_W-1:0] own_vel_x;
		logic signed [DATA_W-1:0] own_vel_y;
		logic signed [DATA_W-1:0] own_vel_z;
		logic signed [DATA_W-1:0] anchor_pos_x;
		logic signed [DATA_W-1:0] anchor_pos_y;
		logic signed [DATA_W-1:0] anchor_pos_z;
		logic signed [DATA_W-1:0] anchor_vel_x;
		logic signed [DATA_W-1:0] anchor_vel_y;
		logic signed [DATA_W-1:0] anchor_vel_z;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] force_x;
		logic signed [DATA_W-1:0] force_y;
		logic signed [DATA_W-1:0] force_z;
		logic                     saturated;
	} out_t;

endpackage

>>> hw/rtl/sdf_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module sdf_isqrt import sdf_pkg::*; #(
	parameter int RW = 2 * DATA_W + 2
) (
	input  logic                clk,
	input  logic                en,
	input  logic [RW-1:0]       rad,
	output logic [RW/2-1:0]     root
);

	localparam int NB = RW / 2;

	logic [NB:0]   rem_s [NB];
	logic [NB-1:0] root_s[NB];
	logic [RW-1:0] rad_s [NB];

	for (genvar j = 0; j < NB; j++) begin : g_stage
		logic [NB:0]   rem_p;
		logic [NB-1:0] root_p;
		logic [RW-1:0] rad_p;
		logic [NB+2:0] cur;
		logic [NB+2:0] trial;

		if (j == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
		end else begin : g_next
			assign rem_p  = rem_s[j-1];
			assign root_p = root_s[j-1];
			assign rad_p  = rad_s[j-1];
		end

		assign cur   = {rem_p, rad_p[RW-1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j] <= rad_p << 2;
				if (cur >= trial) begin
					rem_s[j]  <= (NB+1)'(cur - trial);
					root_s[j] <= {root_p[NB-2:0], 1'b1};
				end else begin
					rem_s[j]  <= cur[NB:0];
					root_s[j] <= {root_p[NB-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[NB-1];

endmodule

>>> hw/rtl/sdf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_div
// Pipelined restoring divider for (num << (QB-1)) / den, num not above den.
// ----------------------------------------------------------------------------
module sdf_div import sdf_pkg::*; #(
	parameter int NW = DATA_W + 1,
	parameter int QB = FRAC_W + 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic [QB-1:0] quo
);

	logic [NW-1:0] r_s  [QB];
	logic [NW-1:0] den_s[QB];
	logic [QB-1:0] q_s  [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [NW:0]   t;
		logic [NW-1:0] d_p;
		logic [QB-1:0] q_p;

		if (k == 0) begin : g_first
			assign t   = {1'b0, num};
			assign d_p = den;
			assign q_p = '0;
		end else begin : g_next
			assign t   = {r_s[k-1], 1'b0};
			assign d_p = den_s[k-1];
			assign q_p = q_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= d_p;
				if (t >= {1'b0, d_p}) begin
					r_s[k] <= NW'(t - {1'b0, d_p});
					q_s[k] <= {q_p[QB-2:0], 1'b1};
				end else begin
					r_s[k] <= t[NW-1:0];
					q_s[k] <= {q_p[QB-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = q_s[QB-1];

endmodule

>>> hw/rtl/spring_damper_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_damper_force
// Damped spring force in 3D: offset, length, direction, tension and damping.
// ----------------------------------------------------------------------------
//  channel   signals                          transfer when
//  input     in_valid, in_stall, in_data      in_valid && !in_stall
//  output    out_valid, out_stall, out_data   out_valid && !out_stall
//  config    cfg_we, cfg_idx, cfg_data        cfg_we
//
//  One item per cycle, except while a result waits under out_stall. Pipeline depth is
//  dominated by the bit-per-stage square root (DATA_W+1) and divider (FRAC_BITS+1) stages.
//  Reset clears valid bits and loads the register defaults.
//  The whole pipeline holds while a result waits under out_stall.
// ----------------------------------------------------------------------------
module spring_damper_force import sdf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int W   = DATA_W;
	localparam int F   = FRAC_BITS;
	localparam int DV  = W + 1;
	localparam int NB  = W + 1;
	localparam int RW  = 2 * W + 2;
	localparam int QB  = F + 1;
	localparam int UW  = F + 2;
	localparam int PW  = DV + UW;
	localparam int DSW = PW + 2;
	localparam int DW  = DSW - F;
	localparam int TPW = 2 * W + 3;
	localparam int TW  = TPW - F;
	localparam int MPW = W + 1 + DW;
	localparam int MW  = MPW - F;
	localparam int SW  = ((TW > MW) ? TW : MW) + 1;
	localparam int FPW = SW + UW;
	localparam int FW  = FPW - F;
	localparam logic [W-1:0] ONE = W'(1) << F;

	typedef struct packed {
		logic [2:0][DV-1:0] dv;
		logic [2:0]         sgn;
		logic [2:0][DV-1:0] mag;
		logic               zero;
	} sba_t;

	typedef struct packed {
		logic [2:0][DV-1:0] dv;
		logic [2:0]         sgn;
		logic               zero;
		logic [NB-1:0]      len;
	} sbb_t;

	logic [W-1:0] rest_q, stiff_q, damp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q  <= ONE;
			stiff_q <= ONE;
			damp_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_REST:  rest_q  <= cfg_data;
				REG_STIFF: stiff_q <= cfg_data;
				REG_DAMP:  damp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	logic signed [W-1:0] apos[3], opos[3], avel[3], ovel[3];
	assign apos = '{in_data.anchor_pos_x, in_data.anchor_pos_y, in_data.anchor_pos_z};
	assign opos = '{in_data.own_pos_x, in_data.own_pos_y, in_data.own_pos_z};
	assign avel = '{in_data.anchor_vel_x, in_data.anchor_vel_y, in_data.anchor_vel_z};
	assign ovel = '{in_data.own_vel_x, in_data.own_vel_y, in_data.own_vel_z};

	// front stages: differences, squares, sum
	logic                 v_s1, v_s2, v_s3;
	logic signed [DV-1:0] d_s1[3], dv_s1[3];
	logic [2:0][DV-1:0]   dv_s2, mag_s2, dv_s3, mag_s3;
	logic [2:0]           sgn_s2, sgn_s3;
	logic [RW-1:0]        sq_s2[3];
	logic [RW-1:0]        sum_s3;
	logic                 zero_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= DV'(apos[i]) - DV'(opos[i]);
				dv_s1[i] <= DV'(avel[i]) - DV'(ovel[i]);
			end
			for (int i = 0; i < 3; i++) begin
				dv_s2[i]  <= dv_s1[i];
				sgn_s2[i] <= d_s1[i][DV-1];
				mag_s2[i] <= d_s1[i][DV-1] ? DV'(-d_s1[i]) : DV'(d_s1[i]);
				sq_s2[i]  <= (d_s1[i][DV-1] ? RW'(DV'(-d_s1[i])) : RW'(DV'(d_s1[i])))
					* (d_s1[i][DV-1] ? RW'(DV'(-d_s1[i])) : RW'(DV'(d_s1[i])));
			end
			dv_s3   <= dv_s2;
			sgn_s3  <= sgn_s2;
			mag_s3  <= mag_s2;
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			zero_s3 <= (mag_s2 == '0);
		end
	end

	// square root with sideband delay
	logic [NB-1:0] len;
	sba_t          sba_in;
	sba_t          sba_q[NB];
	logic [NB-1:0] va_q;

	sdf_isqrt #(.RW(RW)) u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s3),
		.root (len)
	);

	assign sba_in = '{dv: dv_s3, sgn: sgn_s3, mag: mag_s3, zero: zero_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= '0;
		end else if (en) begin
			va_q <= {va_q[NB-2:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sba_q[0] <= sba_in;
			for (int k = 1; k < NB; k++) sba_q[k] <= sba_q[k-1];
		end
	end

	// direction by division
	logic [QB-1:0] quo[3];
	sbb_t          sbb_in;
	sbb_t          sbb_q[QB];
	logic [QB-1:0] vb_q;

	for (genvar i = 0; i < 3; i++) begin : g_div
		sdf_div #(.NW(DV), .QB(QB)) u_div (
			.clk (clk),
			.en  (en),
			.num (sba_q[NB-1].mag[i]),
			.den (len),
			.quo (quo[i])
		);
	end

	assign sbb_in = '{dv: sba_q[NB-1].dv, sgn: sba_q[NB-1].sgn,
		zero: sba_q[NB-1].zero, len: len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q <= '0;
		end else if (en) begin
			vb_q <= {vb_q[QB-2:0], va_q[NB-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sbb_q[0] <= sbb_in;
			for (int k = 1; k < QB; k++) sbb_q[k] <= sbb_q[k-1];
		end
	end

	// back stages: dot, tension, damping, scale, saturate
	logic [6:1] vp;
	logic signed [UW-1:0]  u_p1[3], u_p2[3], u_p3[3], u_p4[3], u_p5[3];
	logic signed [DV-1:0]  dv_p1[3];
	logic signed [W+1:0]   td_p1;
	logic signed [PW-1:0]  pr_p2[3];
	logic signed [TW-1:0]  ten_p2, ten_p3, ten_p4;
	logic signed [DW-1:0]  dot_p3;
	logic signed [MW-1:0]  dmp_p4;
	logic signed [SW-1:0]  s_p5;
	logic signed [FW-1:0]  f_p6[3];
	logic [5:1]            z_p;
	logic                  z_p6;
	logic signed [TPW-1:0] ten_full;
	logic signed [DSW-1:0] dot_full;
	logic signed [MPW-1:0] dmp_full;
	logic signed [FPW-1:0] f_full[3];

	assign ten_full = $signed({1'b0, stiff_q}) * td_p1;
	assign dot_full = pr_p2[0] + pr_p2[1] + pr_p2[2];
	assign dmp_full = $signed({1'b0, damp_q}) * dot_p3;
	for (genvar i = 0; i < 3; i++) begin : g_scale
		assign f_full[i] = s_p5 * u_p5[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp        <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vp        <= {vp[5:1], vb_q[QB-1]};
			out_valid <= vp[6];
		end
	end

	always_ff @(posedge clk) begin
		logic [W-1:0] fo[3];
		logic         sat;
		if (en) begin
			sat = 1'b0;
			for (int i = 0; i < 3; i++) begin
				u_p1[i]  <= sbb_q[QB-1].sgn[i] ? -$signed({1'b0, quo[i]})
					: $signed({1'b0, quo[i]});
				dv_p1[i] <= $signed(sbb_q[QB-1].dv[i]);
				pr_p2[i] <= dv_p1[i] * u_p1[i];
				u_p2[i]  <= u_p1[i];
				u_p3[i]  <= u_p2[i];
				u_p4[i]  <= u_p3[i];
				u_p5[i]  <= u_p4[i];
				f_p6[i]  <= f_full[i][FPW-1:F];
			end
			td_p1  <= $signed({1'b0, sbb_q[QB-1].len}) - $signed({2'b00, rest_q});
			ten_p2 <= ten_full[TPW-1:F];
			ten_p3 <= ten_p2;
			dot_p3 <= dot_full[DSW-1:F];
			ten_p4 <= ten_p3;
			dmp_p4 <= dmp_full[MPW-1:F];
			s_p5   <= ten_p4 - dmp_p4;
			z_p    <= {z_p[4:1], sbb_q[QB-1].zero};
			for (int i = 0; i < 3; i++) begin
				if (!f_p6[i][FW-1] && (|f_p6[i][FW-2:W-1])) begin
					fo[i] = {1'b0, {(W-1){1'b1}}};
					sat   = 1'b1;
				end else if (f_p6[i][FW-1] && !(&f_p6[i][FW-2:W-1])) begin
					fo[i] = {1'b1, {(W-1){1'b0}}};
					sat   = 1'b1;
				end else begin
					fo[i] = f_p6[i][W-1:0];
				end
			end
			if (z_p6) begin
				out_data <= '0;
			end else begin
				out_data <= '{force_x: fo[0], force_y: fo[1], force_z: fo[2],
					saturated: sat};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_p6 <= z_p[5];
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.saturated) |->
			(out_data.force_x == {1'b0, {(W-1){1'b1}}} ||
			 out_data.force_x == {1'b1, {(W-1){1'b0}}} ||
			 out_data.force_y == {1'b0, {(W-1){1'b1}}} ||
			 out_data.force_y == {1'b1, {(W-1){1'b0}}} ||
			 out_data.force_z == {1'b0, {(W-1){1'b1}}} ||
			 out_data.force_z == {1'b1, {(W-1){1'b0}}}))
		else $error("saturated flag without a clipped component");

	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vp) && $stable(vb_q) && $stable(va_q)))
		else $error("pipeline moved during a stall");

endmodule
